// ===== sv/tlsh_pkg.sv =====
// Shared types, constants and the lane step function of the two-lane string hash.
`timescale 1ns / 1ps

package tlsh_pkg;

   localparam int unsigned HashWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CountWidth = 2;

   localparam logic [HashWidth-1:0] HashSeed = 32'd5381;
   localparam logic [HashWidth-1:0] HashMult = 32'd1566083941;
   localparam int unsigned ShiftLeft = 5;
   localparam int unsigned ShiftRight = 27;

   // Per-lane control for one cycle.
   typedef struct packed {
      logic step;     // fold this lane's byte into the accumulator
      logic restart;  // return the accumulator to the seed afterward
   } lane_ctrl_type;

   // One lane update: h*33 plus arithmetic h>>27, then XOR the sign-extended byte.
   function automatic logic [HashWidth-1:0] lane_step(input logic [HashWidth-1:0] h,
                                                      input logic [ByteWidth-1:0] b);
      logic [HashWidth-1:0] asr;
      logic [HashWidth-1:0] bext;
      asr  = {{ShiftRight{h[HashWidth-1]}}, h[HashWidth-1:ShiftRight]};
      bext = {{(HashWidth-ByteWidth){b[ByteWidth-1]}}, b};
      return ((h << ShiftLeft) + h + asr) ^ bext;
   endfunction

endpackage

// ===== sv/tlsh_lane.sv =====
// One hash lane: a 32-bit accumulator that folds in one byte per transaction.
`timescale 1ns / 1ps

module tlsh_lane
   import tlsh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lane_ctrl_type        ctrl,
   input  logic [ByteWidth-1:0] data_byte,
   output logic [HashWidth-1:0] acc_next
);

   logic [HashWidth-1:0] acc_ff;
   logic [HashWidth-1:0] acc_in;

   // The updated value goes to the merge stage even when the lane restarts.
   assign acc_next = ctrl.step ? lane_step(acc_ff, data_byte) : acc_ff;
   assign acc_in   = ctrl.restart ? HashSeed : acc_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= HashSeed;
      end else begin
         acc_ff <= acc_in;
      end
   end

`ifndef SYNTHESIS
   a_restart_seeds: assert property (@(posedge clock) disable iff (reset)
      ctrl.restart |=> (acc_ff == HashSeed))
      else $error("lane did not return to the seed after the end of a string");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (!ctrl.step && !ctrl.restart) |=> $stable(acc_ff))
      else $error("lane accumulator changed without a step");
`endif

endmodule

// ===== sv/tlsh_merge.sv =====
// Merge pipeline: combines both lanes as lane_a + lane_b * multiplier over three stages.
`timescale 1ns / 1ps

module tlsh_merge
   import tlsh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [HashWidth-1:0] in_lane_a,
   input  logic [HashWidth-1:0] in_lane_b,
   output logic                 in_stall,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic [HashWidth-1:0] out_hash
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [HashWidth-1:0] s1_a_ff, s1_b_ff;
   logic                 s2_valid_ff, s2_valid_in;
   logic [HashWidth-1:0] s2_a_ff, s2_prod_ff, s2_prod_in;
   logic                 s3_valid_ff, s3_valid_in;
   logic [HashWidth-1:0] s3_hash_ff, s3_hash_in;
   logic                 s1_load, s2_load, s3_load;

   // Each stage takes new data when it is empty or its contents move on.
   assign s3_load = !s3_valid_ff || !out_stall;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;
   assign in_stall = !s1_load;

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;
   assign s2_prod_in  = s1_b_ff * HashMult;
   assign s3_hash_in  = s2_a_ff + s2_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_load) begin
            s2_valid_ff <= s2_valid_in;
         end
         if (s3_load) begin
            s3_valid_ff <= s3_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_a_ff <= in_lane_a;
         s1_b_ff <= in_lane_b;
      end
      if (s2_load) begin
         s2_a_ff    <= s1_a_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (s3_load) begin
         s3_hash_ff <= s3_hash_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_hash  = s3_hash_ff;

`ifndef SYNTHESIS
   a_flow_when_free: assert property (@(posedge clock) disable iff (reset)
      !out_stall |-> !in_stall)
      else $error("merge pipeline stalled its input while the output was free");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("merge pipeline stalled its input with an empty stage");
`endif

endmodule

// ===== sv/two_lane_string_hash.sv =====
// Top level of the two-lane string hash: input handshake, two lanes and the merge pipeline.
`timescale 1ns / 1ps
// Usage: a byte string arrives on the req_ channel as pairs of bytes, one pair per
// transaction. req_even_byte feeds lane A and req_odd_byte feeds lane B; req_byte_count
// tells how many of them are valid (zero, one or two, with three taken as two), and
// req_ends_string marks the last transaction of a string. A transaction is accepted at a
// rising edge where req_valid is high and req_stall is low.
// Each accepted transaction updates the lanes in that cycle, so one transaction per clock
// is taken sustained while req_stall is low. The final transaction of a string produces
// one rsp_ transaction carrying rsp_hash_value; every other transaction produces none.
// The edge that accepts the final transaction captures the lanes in the first stage of
// the three-stage merge pipeline; the second stage registers the 32x32 multiply and the
// third the final add, which drives rsp_hash_value. The lanes are back at the seed for
// the next string in the very next cycle.
// When the receiver holds rsp_stall high, the result stays on the outputs; the merge
// pipeline keeps filling and raises req_stall only once all three stages hold a result.
// Reset is synchronous and active high: both lanes return to the seed 5381 and the merge
// pipeline is emptied, so no result is pending.
module two_lane_string_hash
   import tlsh_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ByteWidth-1:0]         req_even_byte,
   input  logic [ByteWidth-1:0]         req_odd_byte,
   input  logic [CountWidth-1:0]        req_byte_count,
   input  logic                         req_ends_string,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [HashWidth-1:0]  rsp_hash_value
);

   logic                 req_accept;
   logic                 merge_stall;
   lane_ctrl_type        lane_a_ctrl, lane_b_ctrl;
   logic [HashWidth-1:0] lane_a_next, lane_b_next;
   logic [HashWidth-1:0] hash_out;

   // Any transaction waits while the merge pipeline is full; this keeps the lanes
   // and the stream of results in step.
   assign req_stall  = merge_stall;
   assign req_accept = req_valid && !merge_stall;

   // Lane A steps on any nonzero count; lane B only when two bytes are present.
   assign lane_a_ctrl.step    = req_accept && (req_byte_count != '0);
   assign lane_a_ctrl.restart = req_accept && req_ends_string;
   assign lane_b_ctrl.step    = req_accept && req_byte_count[CountWidth-1];
   assign lane_b_ctrl.restart = req_accept && req_ends_string;

   tlsh_lane u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_a_ctrl),
      .data_byte (req_even_byte),
      .acc_next  (lane_a_next)
   );

   tlsh_lane u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_b_ctrl),
      .data_byte (req_odd_byte),
      .acc_next  (lane_b_next)
   );

   // The merge captures the lanes' updated values on the final transaction.
   tlsh_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept && req_ends_string),
      .in_lane_a (lane_a_next),
      .in_lane_b (lane_b_next),
      .in_stall  (merge_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_hash  (hash_out)
   );

   assign rsp_hash_value = signed'(hash_out);

endmodule
